FILE: src/qls_pkg.sv
// Shared types and constants for the quoted line splitter.
// No dependencies; imported by qls_out_fifo and quoted_line_splitter.
`default_nettype none

package qls_pkg;

   // Longest line the block will ever pass before cutting it
   localparam int LINE_MAX = 4096;
   // Line byte counter must hold LINE_MAX itself
   localparam int CNT_W    = $clog2(LINE_MAX + 1);
   // Width of the max_line_len register
   localparam int MLL_W    = 13;
   // Width used to compare counter and limit
   localparam int CMP_W    = (CNT_W > MLL_W) ? CNT_W : MLL_W;

   // Result queue depth; one input word may push two results
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // Byte codes
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   // Configuration register indexes
   localparam logic [1:0] CSR_SEPARATOR    = 2'd0;
   localparam logic [1:0] CSR_QUOTE_MODE   = 2'd1;
   localparam logic [1:0] CSR_MAX_LINE_LEN = 2'd2;

   // Reset values of the configuration registers
   localparam logic [7:0]       SEPARATOR_RST    = CH_LF;
   localparam logic [MLL_W-1:0] MAX_LINE_LEN_RST = MLL_W'(4096);

   typedef enum logic [1:0] {
      CAUSE_SEP   = 2'd0,
      CAUSE_LIMIT = 2'd1,
      CAUSE_EOD   = 2'd2
   } cause_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       line_end;
      cause_type  end_cause;
   } result_type;

   // Results produced by one input word, in delivery order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

FILE: src/quoted_line_splitter.sv
// Top level of the quoted line splitter: per-byte line logic, state and
// configuration registers. Depends on qls_pkg and qls_out_fifo.
// Results go through a four-deep result queue to rsp. Throughput: one byte per
// cycle while two queue slots are free; a byte may yield two words, which
// drain at one word per cycle while rsp_tready is high.
// Reset: synchronous; clears line state, empties the queue and restores
// separator LF, quote mode off and a line limit of 4096.
`default_nettype none

module quoted_line_splitter
   import qls_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: [7:0] data_byte
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,   // end_of_data
   // rsp_tdata: [7:0] out_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,   // line_end
   // rsp_tuser: [0] has_byte, [2:1] end_cause
   output logic [2:0]       rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [MLL_W-1:0] csr_wdata
);

   // configuration
   logic [7:0]       separator_ff;
   logic             quote_mode_ff;
   logic [MLL_W-1:0] max_line_len_ff;

   // line state
   logic             in_quote_ff,   in_quote_in;
   logic [7:0]       prev_raw_ff,   prev_raw_in;
   logic             prev_valid_ff, prev_valid_in;
   logic             cr_held_ff,    cr_held_in;
   logic [CNT_W-1:0] line_count_ff, line_count_in;

   logic             accept;
   logic             room_two;
   push_type         push;
   result_type       out_word;

   logic [7:0]       b;
   logic             eod;
   logic [CMP_W-1:0] lim;
   logic             crrule;
   logic             escaped;
   logic             sep_match;
   logic             quoted;
   logic             sep_end;
   logic             flush_cr;
   logic             merge_cr;
   logic             hold_cr;
   logic [CNT_W-1:0] cnt_new;
   logic             line_stop;
   cause_type        stop_cause;
   logic             a_valid;
   logic             b_valid;
   logic             b_present;
   result_type       res_a;
   result_type       res_b;

   assign b          = req_tdata;
   assign eod        = req_tlast;
   assign req_tready = room_two && !reset;
   assign accept     = req_tvalid && req_tready;

   // clamp the line limit to 1..LINE_MAX
   always_comb begin
      if (max_line_len_ff == '0) begin
         lim = CMP_W'(1);
      end else if (CMP_W'(max_line_len_ff) > CMP_W'(LINE_MAX)) begin
         lim = CMP_W'(LINE_MAX);
      end else begin
         lim = CMP_W'(max_line_len_ff);
      end
   end

   // per-byte decisions
   always_comb begin
      crrule      = (separator_ff == CH_LF);
      escaped     = prev_valid_ff && (prev_raw_ff == CH_BSLASH);
      in_quote_in = in_quote_ff ^ (quote_mode_ff && (b == CH_QUOTE) && !escaped);
      sep_match   = (b == separator_ff);
      quoted      = quote_mode_ff && in_quote_in;
      sep_end     = sep_match && !quoted;
      // held CR goes out as a plain byte once LF is no longer the separator
      flush_cr    = cr_held_ff && !crrule;
      merge_cr    = cr_held_ff && crrule;

      // count: a separator is not counted and drops a held CR; other bytes count
      if (sep_match) begin
         if (merge_cr && line_count_ff != '0) begin
            cnt_new = line_count_ff - CNT_W'(1);
         end else begin
            cnt_new = line_count_ff;
         end
      end else begin
         cnt_new = line_count_ff + CNT_W'(1);
      end

      hold_cr   = !sep_match && crrule && (b == CH_CR) && !eod && (CMP_W'(cnt_new) < lim);
      a_valid   = flush_cr || (merge_cr && !sep_match);
      b_valid   = sep_end || (!sep_match && !hold_cr);
      line_stop = !sep_end && (eod || (CMP_W'(cnt_new) >= lim));
      stop_cause = eod ? CAUSE_EOD : CAUSE_LIMIT;
      b_present = b_valid || (line_stop && !a_valid);

      // CR slot
      res_a.out_byte  = CH_CR;
      res_a.has_byte  = 1'b1;
      res_a.line_end  = line_stop && !b_valid;
      res_a.end_cause = (line_stop && !b_valid) ? stop_cause : CAUSE_SEP;

      // main slot: byte, separator or empty end marker
      res_b.out_byte  = b_valid ? b : 8'h00;
      res_b.has_byte  = b_valid;
      res_b.line_end  = sep_end || line_stop;
      res_b.end_cause = line_stop ? stop_cause : CAUSE_SEP;

      // next state
      prev_raw_in   = b;
      prev_valid_in = !eod;
      cr_held_in    = hold_cr && !line_stop;
      if (sep_end || line_stop) begin
         line_count_in = '0;
      end else begin
         line_count_in = cnt_new;
      end
   end

   // hand results to the queue in order
   always_comb begin
      push.count  = 2'd0;
      push.first  = res_b;
      push.second = res_b;
      if (accept) begin
         push.count = 2'(a_valid) + 2'(b_present);
         if (a_valid) begin
            push.first = res_a;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff    <= SEPARATOR_RST;
         quote_mode_ff   <= 1'b0;
         max_line_len_ff <= MAX_LINE_LEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEPARATOR:    separator_ff    <= csr_wdata[7:0];
            CSR_QUOTE_MODE:   quote_mode_ff   <= csr_wdata[0];
            CSR_MAX_LINE_LEN: max_line_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // line state advances on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_quote_ff   <= 1'b0;
         prev_raw_ff   <= 8'h00;
         prev_valid_ff <= 1'b0;
         cr_held_ff    <= 1'b0;
         line_count_ff <= '0;
      end else if (accept) begin
         in_quote_ff   <= in_quote_in;
         prev_raw_ff   <= prev_raw_in;
         prev_valid_ff <= prev_valid_in;
         cr_held_ff    <= cr_held_in;
         line_count_ff <= line_count_in;
      end
   end

   qls_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_two  (room_two),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   assign rsp_tdata = out_word.out_byte;
   assign rsp_tlast = out_word.line_end;
   assign rsp_tuser = {out_word.end_cause, out_word.has_byte};

   // a held CR is always counted in the current line
   assert property (@(posedge clock) disable iff (reset)
      cr_held_ff |-> (line_count_ff != '0))
      else $error("held CR with empty line count");

   // line count stays below the hard limit
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(line_count_ff) < CMP_W'(LINE_MAX))
      else $error("line count reached hard limit");

   // an end-of-data word leaves no previous byte and no held CR
   assert property (@(posedge clock) disable iff (reset)
      (accept && eod) |=> (!prev_valid_ff && !cr_held_ff && line_count_ff == '0))
      else $error("state not cleared after end of data");

endmodule

`default_nettype wire

FILE: src/qls_out_fifo.sv
// Result queue of the quoted line splitter: takes up to two results per
// cycle and delivers one per cycle while out_ready is high. Depends on qls_pkg.
`default_nettype none

module qls_out_fifo
   import qls_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push,
   output logic            room_two,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_word
);

   result_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]         count_ff, count_in;
   logic                     pop;
   logic [FIFO_AW-1:0]       wr_next;

   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room_two  = (count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + FIFO_AW'(1);

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store results; payload needs no reset
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   // fill level never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("result queue over depth");

   // a push never overflows the queue
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (32'(count_ff) + 32'(push.count) <= 32'(FIFO_DEPTH)))
      else $error("result queue overflow");

   // a pop empties nothing that was empty
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && push.count == 2'd0) |=> (count_ff == '0))
      else $error("result queue count underflow");

endmodule

`default_nettype wire
